// ----- src/bpa_pkg.sv -----
// Shared types, codes and constants of the bitmap page allocator.
`default_nettype none

package bpa_pkg;

    localparam int WORD_BITS = 8;
    localparam logic [WORD_BITS-1:0] FULL_WORD = 8'hFF;
    localparam int LOW_RESERVED = 256;

    typedef enum logic [1:0] {
        MODE_INIT  = 2'd0,
        MODE_ALLOC = 2'd1,
        MODE_FREE  = 2'd2,
        MODE_NOP   = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_OOM       = 2'd1,
        STAT_RANGE     = 2'd2,
        STAT_NOT_READY = 2'd3
    } status_t;

    typedef struct packed {
        mode_t       mode;
        logic [31:0] free_addr;
    } in_t;

    typedef struct packed {
        logic [28:0] page_addr;
        status_t     status;
        logic [17:0] free_count;
    } out_t;

    typedef enum logic [1:0] {
        OP_PASS  = 2'd0,
        OP_FILL  = 2'd1,
        OP_TAKE  = 2'd2,
        OP_CLEAR = 2'd3
    } word_op_t;

    typedef struct packed {
        word_op_t   op;
        logic       fill_full;
        logic       fill_part;
        logic [2:0] bit_sel;
    } word_ctrl_t;

    typedef struct packed {
        logic [WORD_BITS-1:0] word;
        logic [2:0]           bit_idx;
        logic                 found;
        logic                 changed;
    } word_res_t;

endpackage

`default_nettype wire

// ----- src/bpa_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module bpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16384
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- src/bpa_word_unit.sv -----
// Shared bitmap word unit: fill, take lowest free bit, clear one bit.
`default_nettype none

module bpa_word_unit (
    input  wire bpa_pkg::word_ctrl_t ctrl,
    input  wire logic [7:0]          rd_word,
    output bpa_pkg::word_res_t       res
);

    logic [7:0] bit_mask;
    logic [7:0] low_mask;
    logic [2:0] zero_idx;

    always_comb
    begin
        bit_mask = 8'h01 << ctrl.bit_sel;
        low_mask = bit_mask - 8'h01;
        // lowest clear bit of the word
        zero_idx = 3'd0;
        for (int b = 7; b >= 0; b--)
        begin
            if (!rd_word[b])
            begin
                zero_idx = 3'(b);
            end
        end

        res.word    = rd_word;
        res.bit_idx = zero_idx;
        res.found   = (rd_word != bpa_pkg::FULL_WORD);
        res.changed = 1'b0;

        case (ctrl.op)
            bpa_pkg::OP_FILL:
            begin
                if (ctrl.fill_full)
                begin
                    res.word = bpa_pkg::FULL_WORD;
                end
                else if (ctrl.fill_part)
                begin
                    res.word = low_mask;
                end
                else
                begin
                    res.word = 8'h00;
                end
            end
            bpa_pkg::OP_TAKE:
            begin
                res.word = rd_word | (8'h01 << zero_idx);
            end
            bpa_pkg::OP_CLEAR:
            begin
                res.changed = |(rd_word & bit_mask);
                res.word    = rd_word & ~bit_mask;
            end
            default:
            begin
                res.word = rd_word;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- src/bitmap_page_allocator_core.sv -----
// Top level of the bitmap page allocator: sequencer, counters and result register.
//
//  channel  | direction | handshake          | word
//  ---------+-----------+--------------------+----------------------------------
//  in       | input     | in_valid/in_stall  | bpa_pkg::in_t  (mode, free_addr)
//  out      | output    | out_valid/out_stall| bpa_pkg::out_t (page_addr, status,
//           |           |                    |   free_count)
//  cfg      | input     | cfg_valid/cfg_ready| kernel end byte address (32 bits)
//
// Steps: init goes through a setup state, then writes one bitmap word per cycle
// over the whole store; alloc reads one word per cycle through the single RAM read
// port and stops at the first word that is not full; free reads the word, then
// modifies and writes it back; the other cases go straight to the result.
// One word is worked on at a time; in_stall is high until the sequencer is back idle.
// Reset clears the free-page counter, the ready flag and the kernel end register; the
// bitmap itself is not cleared and becomes defined at the first init.
// A finished result waits in the output register while the next word is taken.
`default_nettype none

module bitmap_page_allocator_core #(
    parameter int TOTAL_PAGE_COUNT = 131072,
    parameter int PAGE_BYTES       = 4096
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_stall,
    input  wire bpa_pkg::in_t  in_word,
    output logic               out_valid,
    input  wire logic          out_stall,
    output bpa_pkg::out_t      out_word,
    input  wire logic          cfg_valid,
    output logic               cfg_ready,
    input  wire logic [31:0]   cfg_data
);

    localparam int WORD_COUNT = TOTAL_PAGE_COUNT / bpa_pkg::WORD_BITS;
    localparam int AW         = $clog2(WORD_COUNT);
    localparam int PW         = AW + 3;
    localparam int CW         = PW + 1;
    localparam int SHIFT      = $clog2(PAGE_BYTES);
    localparam logic [AW-1:0] LAST_WORD = AW'(WORD_COUNT - 1);
    localparam logic [CW-1:0] TOTAL_C   = CW'(TOTAL_PAGE_COUNT);
    localparam logic [31:0]   TOTAL_32  = 32'(TOTAL_PAGE_COUNT);
    localparam logic [31:0]   LOW_LAST  = 32'(bpa_pkg::LOW_RESERVED - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_INIT_SETUP,
        S_INIT_FILL,
        S_SCAN,
        S_FREE_READ,
        S_FREE_WRITE,
        S_DONE
    } state_t;

    state_t              state_reg, state_next;
    logic [AW-1:0]       addr_reg, addr_next;
    logic [AW-1:0]       chk_reg, chk_next;
    logic                chk_valid_reg, chk_valid_next;
    logic [PW-1:0]       page_reg, page_next;
    logic [CW-1:0]       reserve_reg, reserve_next;
    logic [CW-1:0]       free_pages_reg, free_pages_next;
    logic                ready_reg, ready_next;
    logic [31:0]         kend_reg, kend_next;
    logic [28:0]         res_addr_reg, res_addr_next;
    bpa_pkg::status_t    res_status_reg, res_status_next;
    logic                out_valid_reg, out_valid_next;
    bpa_pkg::out_t       out_word_reg, out_word_next;

    logic                ram_wr_en;
    logic [AW-1:0]       ram_wr_addr;
    logic                ram_rd_en;
    logic [AW-1:0]       ram_rd_addr;
    logic [7:0]          ram_rd_data;

    bpa_pkg::word_ctrl_t unit_ctrl;
    bpa_pkg::word_res_t  unit_res;

    logic                out_free;
    logic [31:0]         free_page32;
    logic [31:0]         last32;
    logic [31:0]         last_clamped;
    logic [63:0]         take_wide;

    bpa_ram #(
        .WIDTH (bpa_pkg::WORD_BITS),
        .DEPTH (WORD_COUNT)
    ) u_bitmap (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (unit_res.word),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    bpa_word_unit u_word_unit (
        .ctrl    (unit_ctrl),
        .rd_word (ram_rd_data),
        .res     (unit_res)
    );

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;
    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || !out_stall;

    // page index of a release, and the last reserved page at init
    assign free_page32 = in_word.free_addr >> SHIFT;
    assign last32      = kend_reg >> SHIFT;
    assign take_wide   = 64'({chk_reg, unit_res.bit_idx}) << SHIFT;

    always_comb
    begin
        if (last32 < LOW_LAST)
        begin
            last_clamped = LOW_LAST;
        end
        else if (last32 >= TOTAL_32)
        begin
            last_clamped = TOTAL_32 - 32'd1;
        end
        else
        begin
            last_clamped = last32;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        addr_next       = addr_reg;
        chk_next        = chk_reg;
        chk_valid_next  = chk_valid_reg;
        page_next       = page_reg;
        reserve_next    = reserve_reg;
        free_pages_next = free_pages_reg;
        ready_next      = ready_reg;
        kend_next       = kend_reg;
        res_addr_next   = res_addr_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg;
        out_word_next   = out_word_reg;

        ram_wr_en   = 1'b0;
        ram_wr_addr = addr_reg;
        ram_rd_en   = 1'b0;
        ram_rd_addr = addr_reg;

        unit_ctrl.op        = bpa_pkg::OP_PASS;
        unit_ctrl.fill_full = 1'b0;
        unit_ctrl.fill_part = 1'b0;
        unit_ctrl.bit_sel   = 3'd0;

        if (cfg_valid)
        begin
            kend_next = cfg_data;
        end

        // drop the result once the consumer takes it
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    res_addr_next = 29'd0;
                    case (in_word.mode)
                        bpa_pkg::MODE_INIT:
                        begin
                            state_next = S_INIT_SETUP;
                        end
                        bpa_pkg::MODE_ALLOC:
                        begin
                            if (!ready_reg)
                            begin
                                res_status_next = bpa_pkg::STAT_NOT_READY;
                                state_next      = S_DONE;
                            end
                            else
                            begin
                                addr_next      = '0;
                                chk_valid_next = 1'b0;
                                state_next     = S_SCAN;
                            end
                        end
                        bpa_pkg::MODE_FREE:
                        begin
                            if (!ready_reg)
                            begin
                                res_status_next = bpa_pkg::STAT_NOT_READY;
                                state_next      = S_DONE;
                            end
                            else if (free_page32 >= TOTAL_32)
                            begin
                                res_status_next = bpa_pkg::STAT_RANGE;
                                state_next      = S_DONE;
                            end
                            else
                            begin
                                page_next  = free_page32[PW-1:0];
                                state_next = S_FREE_READ;
                            end
                        end
                        default:
                        begin
                            res_status_next = ready_reg ? bpa_pkg::STAT_OK
                                                        : bpa_pkg::STAT_NOT_READY;
                            state_next      = S_DONE;
                        end
                    endcase
                end
            end

            S_INIT_SETUP:
            begin
                reserve_next    = CW'(last_clamped + 32'd1);
                free_pages_next = TOTAL_C - CW'(last_clamped + 32'd1);
                ready_next      = 1'b1;
                addr_next       = '0;
                state_next      = S_INIT_FILL;
            end

            S_INIT_FILL:
            begin
                // full words below the reserve edge, a partial word at it, empty words above
                unit_ctrl.op        = bpa_pkg::OP_FILL;
                unit_ctrl.fill_full = ({1'b0, addr_reg} < reserve_reg[CW-1:3]);
                unit_ctrl.fill_part = ({1'b0, addr_reg} == reserve_reg[CW-1:3]);
                unit_ctrl.bit_sel   = reserve_reg[2:0];
                ram_wr_en           = 1'b1;
                if (addr_reg == LAST_WORD)
                begin
                    res_status_next = bpa_pkg::STAT_OK;
                    state_next      = S_DONE;
                end
                else
                begin
                    addr_next = addr_reg + AW'(1);
                end
            end

            S_SCAN:
            begin
                // issue one read per cycle, check the word read the cycle before
                ram_rd_en      = 1'b1;
                chk_next       = addr_reg;
                chk_valid_next = 1'b1;
                if (addr_reg != LAST_WORD)
                begin
                    addr_next = addr_reg + AW'(1);
                end
                if (chk_valid_reg)
                begin
                    unit_ctrl.op = bpa_pkg::OP_TAKE;
                    if (unit_res.found)
                    begin
                        ram_wr_en       = 1'b1;
                        ram_wr_addr     = chk_reg;
                        free_pages_next = free_pages_reg - CW'(1);
                        res_addr_next   = take_wide[28:0];
                        res_status_next = bpa_pkg::STAT_OK;
                        state_next      = S_DONE;
                    end
                    else if (chk_reg == LAST_WORD)
                    begin
                        res_status_next = bpa_pkg::STAT_OOM;
                        state_next      = S_DONE;
                    end
                end
            end

            S_FREE_READ:
            begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = page_reg[PW-1:3];
                state_next  = S_FREE_WRITE;
            end

            S_FREE_WRITE:
            begin
                unit_ctrl.op      = bpa_pkg::OP_CLEAR;
                unit_ctrl.bit_sel = page_reg[2:0];
                if (unit_res.changed)
                begin
                    ram_wr_en       = 1'b1;
                    ram_wr_addr     = page_reg[PW-1:3];
                    free_pages_next = free_pages_reg + CW'(1);
                end
                res_status_next = bpa_pkg::STAT_OK;
                state_next      = S_DONE;
            end

            S_DONE:
            begin
                // hold until the output register is free
                if (out_free)
                begin
                    out_valid_next           = 1'b1;
                    out_word_next.page_addr  = res_addr_reg;
                    out_word_next.status     = res_status_reg;
                    out_word_next.free_count = 18'(free_pages_reg);
                    state_next               = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            addr_reg       <= '0;
            chk_reg        <= '0;
            chk_valid_reg  <= 1'b0;
            page_reg       <= '0;
            reserve_reg    <= '0;
            free_pages_reg <= '0;
            ready_reg      <= 1'b0;
            kend_reg       <= '0;
            res_addr_reg   <= '0;
            res_status_reg <= bpa_pkg::STAT_OK;
            out_valid_reg  <= 1'b0;
            out_word_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            addr_reg       <= addr_next;
            chk_reg        <= chk_next;
            chk_valid_reg  <= chk_valid_next;
            page_reg       <= page_next;
            reserve_reg    <= reserve_next;
            free_pages_reg <= free_pages_next;
            ready_reg      <= ready_next;
            kend_reg       <= kend_next;
            res_addr_reg   <= res_addr_next;
            res_status_reg <= res_status_next;
            out_valid_reg  <= out_valid_next;
            out_word_reg   <= out_word_next;
        end
    end

    // the free-page counter never exceeds the store
    a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
        free_pages_reg <= TOTAL_C)
        else $error("free page count beyond store size");

    // bitmap writes only come from fill, alloc hit or free write
    a_write_state : assert property (@(posedge clk) disable iff (!rst_n)
        ram_wr_en |-> (state_reg == S_INIT_FILL || state_reg == S_SCAN ||
                       state_reg == S_FREE_WRITE))
        else $error("bitmap write outside a writing state");

    // an accepted word closes the input until the sequencer is idle again
    a_accept_busy : assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input open right after accept");

    // a finished result reaches the output register once the slot is free
    a_done_emit : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && out_free) |=> (out_valid && state_reg == S_IDLE))
        else $error("result not delivered from done state");

endmodule

`default_nettype wire

// ----- dv/bitmap_page_allocator_core_checker.sv -----
// Result checker for the bitmap page allocator: tracks the page bitmap and compares every result.
`timescale 1ns / 1ps

module bitmap_page_allocator_core_checker #(
    parameter int TOTAL_PAGE_COUNT = 131072,
    parameter int PAGE_BYTES       = 4096
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic          in_stall,
    input  bpa_pkg::in_t  in_word,
    input  logic          out_valid,
    input  logic          out_stall,
    input  bpa_pkg::out_t out_word,
    input  logic          cfg_valid,
    input  logic          cfg_ready,
    input  logic [31:0]   cfg_data,
    output int            errors,
    output int            pending,
    output int            checked
);
    import bpa_pkg::*;

    localparam int MAP_WORDS = (TOTAL_PAGE_COUNT + WORD_BITS - 1) / WORD_BITS;

    logic [WORD_BITS-1:0] page_map [MAP_WORDS];
    logic [31:0]          free_total;
    logic                 map_ready;
    logic [31:0]          kernel_end;
    out_t                 awaited_results [$];
    out_t                 want;

    // Apply one word to the page map and return the result it should produce.
    function automatic out_t allocator_result(in_t w);
        out_t        r;
        logic [31:0] last;
        logic [31:0] page;
        logic [31:0] byte_addr;
        int          wi;
        int          bi;
        bit          found;
        r = '0;
        r.status = STAT_OK;
        if (w.mode == MODE_INIT) begin
            last = kernel_end / PAGE_BYTES;
            if (last < LOW_RESERVED - 1)
                last = LOW_RESERVED - 1;
            if (last >= TOTAL_PAGE_COUNT)
                last = TOTAL_PAGE_COUNT - 1;
            for (wi = 0; wi < MAP_WORDS; wi++)
                page_map[wi] = '0;
            for (page = 0; page <= last; page++)
                page_map[page / WORD_BITS][page % WORD_BITS] = 1'b1;
            free_total = TOTAL_PAGE_COUNT - (last + 1);
            map_ready = 1'b1;
        end else if (!map_ready) begin
            r.status = STAT_NOT_READY;
        end else if (w.mode == MODE_ALLOC) begin
            found = 1'b0;
            for (wi = 0; wi < MAP_WORDS && !found; wi++) begin
                if (page_map[wi] != FULL_WORD) begin
                    for (bi = 0; bi < WORD_BITS && !found; bi++) begin
                        page = wi * WORD_BITS + bi;
                        if (page < TOTAL_PAGE_COUNT && !page_map[wi][bi]) begin
                            page_map[wi][bi] = 1'b1;
                            free_total = free_total - 1;
                            byte_addr = page * PAGE_BYTES;
                            r.page_addr = byte_addr[28:0];
                            found = 1'b1;
                        end
                    end
                end
            end
            if (!found)
                r.status = STAT_OOM;
        end else if (w.mode == MODE_FREE) begin
            page = w.free_addr / PAGE_BYTES;
            if (page >= TOTAL_PAGE_COUNT) begin
                r.status = STAT_RANGE;
            end else if (page_map[page / WORD_BITS][page % WORD_BITS]) begin
                page_map[page / WORD_BITS][page % WORD_BITS] = 1'b0;
                free_total = free_total + 1;
            end
        end
        r.free_count = free_total[17:0];
        return r;
    endfunction

    // Compare before taking a new word: a word cannot produce its result at the edge it is taken.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            awaited_results.delete();
            free_total = '0;
            map_ready  = 1'b0;
            kernel_end = '0;
            errors     = 0;
            checked    = 0;
            pending    = 0;
        end else begin
            if (cfg_valid && cfg_ready)
                kernel_end = cfg_data;
            if (out_valid && !out_stall) begin
                if (awaited_results.size() == 0) begin
                    $error("result with none awaited: page_addr %0h status %0d free_count %0d",
                           out_word.page_addr, out_word.status, out_word.free_count);
                    errors++;
                end else begin
                    want = awaited_results.pop_front();
                    checked++;
                    if (out_word.page_addr !== want.page_addr) begin
                        $error("page_addr: expected %0h, got %0h",
                               want.page_addr, out_word.page_addr);
                        errors++;
                    end
                    if (out_word.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, out_word.status);
                        errors++;
                    end
                    if (out_word.free_count !== want.free_count) begin
                        $error("free_count: expected %0d, got %0d",
                               want.free_count, out_word.free_count);
                        errors++;
                    end
                end
            end
            if (in_valid && !in_stall)
                awaited_results.push_back(allocator_result(in_word));
            pending = awaited_results.size();
        end
    end

endmodule

// ----- dv/bitmap_page_allocator_core_tb.sv -----
// Testbench top for the bitmap page allocator: stimulus, flow control and the final verdict.
`timescale 1ns / 1ps

module bitmap_page_allocator_core_tb;
    import bpa_pkg::*;

    localparam int PAGES          = 131072;
    localparam int BYTES_PER_PAGE = 4096;
    localparam int HOLD_CYCLES    = 400;
    localparam int TAIL_CYCLES    = 32;
    // About 100 words, each at worst a full bitmap pass plus sender gaps and receiver
    // stalls, set the worst case; the limit allows about six times that.
    localparam longint LIMIT_CYCLES = 10_000_000;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    in_t         in_word   = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    out_t        out_word;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [31:0] cfg_data  = '0;

    int     errors;
    int     pending;
    int     checked;
    int     send_idle_pct = 17;
    int     recv_idle_pct = 56;
    logic   hold_on = 1'b0;
    event   hold_go;
    longint cycle_count = 0;
    int     sent_init = 0;
    int     sent_alloc = 0;
    int     sent_free = 0;
    int     sent_nop = 0;
    int     cfg_writes = 0;

    bitmap_page_allocator_core #(
        .TOTAL_PAGE_COUNT (PAGES),
        .PAGE_BYTES       (BYTES_PER_PAGE)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    bitmap_page_allocator_core_checker #(
        .TOTAL_PAGE_COUNT (PAGES),
        .PAGE_BYTES       (BYTES_PER_PAGE)
    ) u_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .pending   (pending),
        .checked   (checked)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Receiver: stall at the phase's rate, or hard while a long hold-off runs.
    always @(posedge clk)
    begin
        if (hold_on)
            out_stall <= 1'b1;
        else
            out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Long hold-off, counted here so the sender keeps offering words meanwhile
    // and the block has to fill its output register and stall its input.
    initial
    begin
        forever
        begin
            @(hold_go);
            hold_on <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            hold_on <= 1'b0;
        end
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("bitmap_page_allocator_core_tb: FAIL");
            $finish;
        end
    end

    // Offer one word and return right after the edge that takes it. Leave valid
    // high so a following word can go back to back; the next call or a drain
    // decides whether it drops.
    task automatic push_word(input mode_t m, input logic [31:0] addr);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= '{mode: m, free_addr: addr};
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        case (m)
            MODE_INIT:  sent_init++;
            MODE_ALLOC: sent_alloc++;
            MODE_FREE:  sent_free++;
            default:    sent_nop++;
        endcase
    endtask

    // Drop valid and hold off until every awaited result has been taken.
    task automatic wait_all_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // Write the kernel end address; only called with the block drained.
    task automatic write_kernel_end(input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        cfg_writes++;
    endtask

    // One setting of the kernel end address followed by random traffic. Most frees aim
    // at pages up to just above the reserved area, where allocations land, so bits really flip;
    // the rest are noise, pages at the top of the store and unused-mode words.
    task automatic random_phase(input logic [31:0] kend, input int count, input bit squeeze);
        int unsigned hot_pages;
        int unsigned page;
        int unsigned roll;
        int          k;
        wait_all_results();
        write_kernel_end(kend);
        hot_pages = kend / BYTES_PER_PAGE + 1;
        if (hot_pages < LOW_RESERVED)
            hot_pages = LOW_RESERVED;
        if (hot_pages > PAGES)
            hot_pages = PAGES;
        hot_pages = hot_pages + 64;
        push_word(MODE_INIT, $urandom());
        for (k = 0; k < count; k++)
        begin
            if (squeeze && k == count / 3)
                ->hold_go;
            // pause the sender once per phase until the block is empty
            if (k == (2 * count) / 3)
                wait_all_results();
            roll = $urandom_range(99);
            if (roll < 42)
            begin
                push_word(MODE_ALLOC, $urandom());
            end
            else if (roll < 77)
            begin
                page = $urandom_range(hot_pages - 1);
                push_word(MODE_FREE,
                          page * BYTES_PER_PAGE + $urandom_range(BYTES_PER_PAGE - 1));
            end
            else if (roll < 85)
            begin
                push_word(MODE_FREE, $urandom());
            end
            else if (roll < 91)
            begin
                page = $urandom_range(PAGES - 1, PAGES - 16);
                push_word(MODE_FREE,
                          page * BYTES_PER_PAGE + $urandom_range(BYTES_PER_PAGE - 1));
            end
            else if (roll < 97)
            begin
                push_word(MODE_NOP, $urandom());
            end
            else
            begin
                push_word(MODE_INIT, $urandom());
            end
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Before the first init: alloc, free and the unused mode report not ready.
        push_word(MODE_ALLOC, 32'h0000_0000);
        push_word(MODE_FREE, 32'h0000_1000);
        push_word(MODE_NOP, 32'hFFFF_FFFF);

        // Smallest kernel: only the low 256 pages get reserved.
        wait_all_results();
        write_kernel_end(32'h0000_0000);
        push_word(MODE_INIT, 32'h0000_0000);
        push_word(MODE_ALLOC, 32'h0000_0000);
        // release page 0 and take it back: a good allocation at address 0
        push_word(MODE_FREE, 32'h0000_0000);
        push_word(MODE_ALLOC, 32'hFFFF_FFFF);
        push_word(MODE_FREE, 32'h0010_0FFF);
        push_word(MODE_FREE, 32'h0010_0000);   // page already free
        push_word(MODE_FREE, 32'h2000_0000);   // first page past the store
        push_word(MODE_FREE, 32'hFFFF_FFFF);
        push_word(MODE_FREE, 32'h1FFF_FFFF);   // last page, still free
        push_word(MODE_NOP, 32'h5555_AAAA);

        // Kernel ends two pages short of the top: drain the last pages, then run dry.
        wait_all_results();
        write_kernel_end(32'h1FFF_D000);
        push_word(MODE_INIT, 32'hAAAA_5555);
        push_word(MODE_ALLOC, 32'h0000_0000);
        push_word(MODE_ALLOC, 32'h0000_0000);
        push_word(MODE_ALLOC, 32'h0000_0000);
        push_word(MODE_FREE, 32'h1FFF_F000);
        push_word(MODE_ALLOC, 32'h0000_0000);

        // Largest kernel: reservation saturates, nothing is free.
        wait_all_results();
        write_kernel_end(32'hFFFF_FFFF);
        push_word(MODE_INIT, 32'h0000_0000);
        push_word(MODE_ALLOC, 32'h0000_0000);
        push_word(MODE_FREE, 32'h0000_0FFF);
        push_word(MODE_ALLOC, 32'h0000_0000);

        // Random traffic: sender idles lightly, receiver heavily; then swap; then none.
        random_phase($urandom_range(32'h000F_FFFF), 25, 1'b0);
        send_idle_pct = 56;
        recv_idle_pct = 17;
        random_phase($urandom_range(32'h0080_0000, 32'h0010_0000), 25, 1'b0);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(32'h000F_FFFF, 25, 1'b1);

        wait_all_results();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d words: %0d init, %0d alloc, %0d free, %0d unused mode",
                 sent_init + sent_alloc + sent_free + sent_nop,
                 sent_init, sent_alloc, sent_free, sent_nop);
        $display("%0d results compared over %0d kernel_end settings, %0d-cycle output hold-off",
                 checked, cfg_writes, HOLD_CYCLES);
        if (errors == 0 && pending == 0)
            $display("bitmap_page_allocator_core_tb: PASS");
        else
            $display("bitmap_page_allocator_core_tb: FAIL");
        $finish;
    end

endmodule
